### src/cfb_pkg.sv
`default_nettype none

package cfb_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned LEN_W          = 16;
  localparam int unsigned HEADER_BYTES   = 5;
  localparam int unsigned CHECKSUM_BYTES = 2;
  localparam int unsigned FIFO_DEPTH     = 4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

  // Input mode codes
  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_PAYLOAD = 1'b1;

  // Byte position within one request's run of output bytes
  localparam int unsigned STEP_W = $clog2(HEADER_BYTES + CHECKSUM_BYTES);
  localparam logic [STEP_W-1:0] ST_SYNC0     = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_SYNC1     = STEP_W'(1);
  localparam logic [STEP_W-1:0] ST_TYPE      = STEP_W'(2);
  localparam logic [STEP_W-1:0] ST_LEN_LO    = STEP_W'(3);
  localparam logic [STEP_W-1:0] ST_LEN_HI    = STEP_W'(HEADER_BYTES - 1);
  localparam logic [STEP_W-1:0] ST_HDR_CSUM0 = STEP_W'(HEADER_BYTES);
  localparam logic [STEP_W-1:0] ST_HDR_CSUM1 = STEP_W'(HEADER_BYTES + 1);
  localparam logic [STEP_W-1:0] ST_PAY_DATA  = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_PAY_CSUM0 = STEP_W'(1);
  localparam logic [STEP_W-1:0] ST_PAY_CSUM1 = STEP_W'(2);

  typedef struct packed {
    logic             mode;
    logic [BYTE_W-1:0] frame_type;
    logic [LEN_W-1:0]  payload_length;
    logic [BYTE_W-1:0] payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_in_run;
    logic              error;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_ERROR = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic              close;  // frame ends with this command: emit checksum
    logic [BYTE_W-1:0] data;   // frame type or payload byte
    logic [LEN_W-1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
  } sync_t;

endpackage

`default_nettype wire

### src/cfb_front.sv
`default_nettype none

module cfb_front import cfb_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  input  wire logic     full_i,
  output logic          push_o,
  output cmd_t          cmd_o
);

  logic [LEN_W-1:0] rem_q, rem_d;
  logic             accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  // Classify the request and track the open frame
  always_comb begin
    rem_d      = rem_q;
    cmd_o.kind = CMD_ERROR;
    cmd_o.close = 1'b0;
    cmd_o.data = in_item_i.payload_byte;
    cmd_o.len  = in_item_i.payload_length;
    if (in_item_i.mode == MODE_START) begin
      cmd_o.kind  = CMD_START;
      cmd_o.data  = in_item_i.frame_type;
      cmd_o.close = (in_item_i.payload_length == '0);
      rem_d       = in_item_i.payload_length;
    end else if (rem_q != '0) begin
      cmd_o.kind  = CMD_DATA;
      cmd_o.close = (rem_q == LEN_W'(1));
      rem_d       = rem_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (accept) begin
      rem_q <= rem_d;
    end
  end

endmodule

`default_nettype wire

### src/cfb_fifo.sv
`default_nettype none

module cfb_fifo import cfb_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      cmd_o,
  output logic      empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !full_o)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT)
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

### src/cfb_back.sv
`default_nettype none

module cfb_back import cfb_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire sync_t sync_i,
  input  wire logic  empty_i,
  input  wire cmd_t  cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output out_item_t  out_item_o
);

  logic [STEP_W-1:0] step_q;
  logic [BYTE_W-1:0] sf_q, ss_q, sf_d, ss_d;
  logic              out_valid_q;
  out_item_t         out_q, res;
  logic              emit, is_data, restart;
  logic [BYTE_W-1:0] data_b;

  assign emit        = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o       = emit && res.last_in_run;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Pick the byte for the current step of the head command
  always_comb begin
    res     = '0;
    is_data = 1'b0;
    restart = 1'b0;
    data_b  = '0;
    unique case (cmd_i.kind)
      CMD_START: begin
        case (step_q)
          ST_SYNC0: begin
            data_b  = sync_i.first;
            is_data = 1'b1;
            restart = 1'b1;
          end
          ST_SYNC1: begin
            data_b  = sync_i.second;
            is_data = 1'b1;
          end
          ST_TYPE: begin
            data_b  = cmd_i.data;
            is_data = 1'b1;
          end
          ST_LEN_LO: begin
            data_b  = cmd_i.len[BYTE_W-1:0];
            is_data = 1'b1;
          end
          ST_LEN_HI: begin
            data_b          = cmd_i.len[LEN_W-1:BYTE_W];
            is_data         = 1'b1;
            res.last_in_run = !cmd_i.close;
          end
          ST_HDR_CSUM0: res.out_byte = sf_q;
          ST_HDR_CSUM1: begin
            res.out_byte    = ss_q;
            res.last_in_run = 1'b1;
          end
          default: res.last_in_run = 1'b1;
        endcase
      end
      CMD_DATA: begin
        case (step_q)
          ST_PAY_DATA: begin
            data_b          = cmd_i.data;
            is_data         = 1'b1;
            res.last_in_run = !cmd_i.close;
          end
          ST_PAY_CSUM0: res.out_byte = sf_q;
          ST_PAY_CSUM1: begin
            res.out_byte    = ss_q;
            res.last_in_run = 1'b1;
          end
          default: res.last_in_run = 1'b1;
        endcase
      end
      CMD_ERROR: begin
        res.last_in_run = 1'b1;
        res.error       = 1'b1;
      end
      default: res.last_in_run = 1'b1;
    endcase
    if (is_data) begin
      res.out_byte = data_b;
    end
  end

  // Two running byte sums, restarted on the first sync byte
  always_comb begin
    sf_d = (restart ? '0 : sf_q) + data_b;
    ss_d = (restart ? '0 : ss_q) + sf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      sf_q        <= '0;
      ss_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        step_q      <= res.last_in_run ? '0 : step_q + STEP_W'(1);
        out_valid_q <= 1'b1;
        if (is_data) begin
          sf_q <= sf_d;
          ss_q <= ss_d;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

`ifndef SYNTH
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && res.error |-> res.last_in_run && pop_o)
    else $error("error result must end its run");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= ST_HDR_CSUM1)
    else $error("step counter out of range");
  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> step_q == '0)
    else $error("step counter not cleared after pop");
`endif

endmodule

`default_nettype wire

### src/checksummed_frame_builder_top.sv
// Checksummed frame builder.
// Input channel (in_valid_i / in_ready_o / in_item_i): a request with mode 0
// starts a frame and produces five header bytes (sync_first, sync_second,
// frame type, length low, length high); with mode 1 it supplies one payload
// byte. After the last payload byte, or right after the header of a
// zero-length frame, two checksum bytes follow (running sum, sum of sums).
// A payload request with no open frame produces one error byte.
// Output channel (out_valid_o / out_ready_i / out_item_o): one byte per
// accepted transfer; last_in_run marks the final byte of each request.
// Config port: write cfg_wdata_i to register cfg_idx_i while cfg_we_i is high;
// write only while the block is idle.
// A request passes the command queue and the output register before its
// first byte is valid. One output byte per cycle while the queue holds a
// command and out_ready_i allows, set by the single back-end emitter; a payload
// request gives 1 byte (3 if it closes the frame), a start 5 (7 for length 0).
// A FIFO_DEPTH-entry command queue sits between classifier and emitter.
// Reset clears the sync registers, the open frame and the queue.
// When the receiver stalls, the output byte holds, the queue fills, and
// in_ready_o drops once the queue is full.
`default_nettype none

module checksummed_frame_builder_top import cfb_pkg::*; #(
  parameter int unsigned FIFO_DEPTH_P = FIFO_DEPTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [BYTE_W-1:0]    cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_item_t             in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_item_t                 out_item_o
);

  sync_t sync_q;
  logic  push, pop, full, empty;
  cmd_t  push_cmd, head_cmd;

  // Hold the sync bytes written by software
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYNC_FIRST:  sync_q.first  <= cfg_wdata_i;
        CFG_SYNC_SECOND: sync_q.second <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Classify each request against the open frame
  cfb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Decouple classification from byte emission
  cfb_fifo #(
    .DEPTH (FIFO_DEPTH_P)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (empty)
  );

  // Emit bytes and checksums, one per cycle while the output is not stalled
  cfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sync_i      (sync_q),
    .empty_i     (empty),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

### bench/tb_checksummed_frame_builder_top.sv
`timescale 1ns / 100ps

module tb_checksummed_frame_builder_top;
  import cfb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned PHASE_ITEMS  = 102;
  localparam int unsigned IDLE_PERCENT = 24;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_SYNC_FIRST;
  logic [BYTE_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_item = '0;
  logic                 out_valid_o;
  logic                 out_ready = 1'b0;
  out_item_t            out_item_o;

  checksummed_frame_builder_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o)
  );

  // Requests waiting to be driven, and framed bytes still owed by the block.
  in_item_t  request_q[$];
  out_item_t stream_q[$];

  // Shadow of the block: sync registers and the open frame.
  logic [BYTE_W-1:0] sync_first_r  = '0;
  logic [BYTE_W-1:0] sync_second_r = '0;
  logic [LEN_W-1:0]  bytes_left    = '0;
  logic [BYTE_W-1:0] sum_first     = '0;
  logic [BYTE_W-1:0] sum_second    = '0;
  logic              frame_open    = 1'b0;

  // When set, neither side idles.
  bit steady = 1'b0;

  int unsigned cycles     = 0;
  int unsigned mismatches = 0;
  int unsigned queued     = 0;
  int unsigned n_starts   = 0;
  int unsigned n_empty    = 0;
  int unsigned n_payload  = 0;
  int unsigned n_stray    = 0;
  int unsigned n_closed   = 0;
  int unsigned n_bytes    = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------

  // Emit one stream byte and fold it into both running sums.
  function automatic void add_stream_byte(logic [BYTE_W-1:0] b, logic last);
    out_item_t r;
    sum_first  = sum_first + b;
    sum_second = sum_second + sum_first;
    r.out_byte    = b;
    r.last_in_run = last;
    r.error       = 1'b0;
    stream_q = {stream_q, r};
  endfunction

  // Close the frame: both checksum bytes, the second one ends the run.
  function automatic void add_checksum();
    out_item_t r;
    r.out_byte    = sum_first;
    r.last_in_run = 1'b0;
    r.error       = 1'b0;
    stream_q = {stream_q, r};
    r.out_byte    = sum_second;
    r.last_in_run = 1'b1;
    stream_q = {stream_q, r};
    frame_open = 1'b0;
    bytes_left = '0;
    n_closed++;
  endfunction

  function automatic void predict_frame_bytes(in_item_t req);
    out_item_t r;
    if (req.mode == MODE_START) begin
      // A start always restarts the sums and drops whatever frame was open.
      n_starts++;
      sum_first  = '0;
      sum_second = '0;
      add_stream_byte(sync_first_r, 1'b0);
      add_stream_byte(sync_second_r, 1'b0);
      add_stream_byte(req.frame_type, 1'b0);
      add_stream_byte(req.payload_length[7:0], 1'b0);
      add_stream_byte(req.payload_length[15:8], req.payload_length != '0);
      if (req.payload_length == '0) begin
        n_empty++;
        add_checksum();
      end else begin
        frame_open = 1'b1;
        bytes_left = req.payload_length;
      end
    end else if (!frame_open || bytes_left == '0) begin
      // Stray payload: one error byte, state untouched.
      n_stray++;
      r.out_byte    = '0;
      r.last_in_run = 1'b1;
      r.error       = 1'b1;
      stream_q = {stream_q, r};
    end else begin
      n_payload++;
      bytes_left = bytes_left - LEN_W'(1);
      if (bytes_left == '0) begin
        add_stream_byte(req.payload_byte, 1'b0);
        add_checksum();
      end else begin
        add_stream_byte(req.payload_byte, 1'b1);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present queued requests, predict on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : request_driver
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        predict_frame_bytes(in_item);
      end
      // Hold valid and payload until the current request is taken.
      if (!in_valid || in_ready_o) begin
        if (request_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
          in_item  <= request_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted byte against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : stream_monitor
    out_item_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        n_bytes++;
        if (stream_q.size() == 0) begin
          $display("%0t: unexpected byte: expected none, actual byte %h last %b error %b",
                   $time, out_item_o.out_byte, out_item_o.last_in_run, out_item_o.error);
          mismatches++;
        end else begin
          want = stream_q.pop_front();
          if (out_item_o.out_byte !== want.out_byte) begin
            $display("%0t: out_byte mismatch: expected %h, actual %h",
                     $time, want.out_byte, out_item_o.out_byte);
            mismatches++;
          end
          if (out_item_o.last_in_run !== want.last_in_run) begin
            $display("%0t: last_in_run mismatch: expected %b, actual %b",
                     $time, want.last_in_run, out_item_o.last_in_run);
            mismatches++;
          end
          if (out_item_o.error !== want.error) begin
            $display("%0t: error mismatch: expected %b, actual %b",
                     $time, want.error, out_item_o.error);
            mismatches++;
          end
        end
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d requests and %0d bytes outstanding",
               $time, request_q.size(), stream_q.size());
      $display("tb_checksummed_frame_builder_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Unused fields carry random junk so every input bit toggles.
  function automatic in_item_t start_req(logic [BYTE_W-1:0] ftype, logic [LEN_W-1:0] len);
    in_item_t r;
    r.mode           = MODE_START;
    r.frame_type     = ftype;
    r.payload_length = len;
    r.payload_byte   = BYTE_W'($urandom_range(255));
    return r;
  endfunction

  function automatic in_item_t payload_req(logic [BYTE_W-1:0] b);
    in_item_t r;
    r.mode           = MODE_PAYLOAD;
    r.frame_type     = BYTE_W'($urandom_range(255));
    r.payload_length = LEN_W'($urandom_range(65535));
    r.payload_byte   = b;
    return r;
  endfunction

  task automatic queue_req(in_item_t r);
    request_q = {request_q, r};
    queued++;
  endtask

  // Mostly complete frames with random content; some truncated (the next
  // start drops them), some stray payload bytes.
  task automatic queue_random_frame();
    int unsigned roll;
    int unsigned len;
    int unsigned n;
    roll = $urandom_range(99);
    if (roll < 8) begin
      repeat ($urandom_range(3, 1)) queue_req(payload_req(BYTE_W'($urandom_range(255))));
    end else begin
      if (roll < 78)      len = $urandom_range(12);
      else if (roll < 92) len = $urandom_range(40, 13);
      else                len = $urandom_range(65535);
      n = len;
      // Long frames are always cut short; short ones sometimes.
      if (len > 40)
        n = $urandom_range(6);
      else if (len != 0 && $urandom_range(99) < 15)
        n = $urandom_range(len - 1);
      queue_req(start_req(BYTE_W'($urandom_range(255)), LEN_W'(len)));
      repeat (n) queue_req(payload_req(BYTE_W'($urandom_range(255))));
    end
  endtask

  // Wait until every request is taken and every byte has come back.
  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid || stream_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_sync(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (idx == CFG_SYNC_FIRST) sync_first_r = val;
    else                       sync_second_r = val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    logic [BYTE_W-1:0] first_set[4];
    logic [BYTE_W-1:0] second_set[4];
    first_set  = '{8'hFF, 8'h00, 8'hFF, BYTE_W'($urandom_range(255))};
    second_set = '{8'h00, 8'hFF, 8'hFF, BYTE_W'($urandom_range(255))};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, sync bytes still at their reset value.
    queue_req(payload_req(8'hFF));                 // payload with no frame open
    queue_req(start_req(8'h00, 16'h0000));         // zero-length frame
    queue_req(start_req(8'hFF, 16'h0001));         // one-byte frame
    queue_req(payload_req(8'hFF));
    queue_req(payload_req(8'h7F));                 // overrun after close
    queue_req(start_req(8'hA5, 16'hFFFF));         // longest length, left open
    queue_req(payload_req(8'h00));
    queue_req(payload_req(8'h80));
    queue_req(start_req(8'h5A, 16'h0002));         // start drops the open frame
    queue_req(payload_req(8'h01));
    queue_req(payload_req(8'hFE));
    queue_req(payload_req(8'h33));                 // stray again
    queue_req(start_req(8'h80, 16'h0100));         // low length byte zero
    queue_req(payload_req(8'h55));
    queue_req(start_req(8'h01, 16'h00FF));
    queue_req(payload_req(8'hAA));
    wait_idle();

    // Random phases, one sync setting each; the second phase never idles.
    for (int p = 0; p < 4; p++) begin
      write_sync(CFG_SYNC_FIRST, first_set[p]);
      write_sync(CFG_SYNC_SECOND, second_set[p]);
      steady = (p == 1);
      queued = 0;
      while (queued < PHASE_ITEMS) queue_random_frame();
      wait_idle();
    end

    $display("covered %0d starts (%0d zero-length), %0d payload bytes, %0d stray payloads,",
             n_starts, n_empty, n_payload, n_stray);
    $display("%0d checksummed frames, %0d output bytes over five sync settings",
             n_closed, n_bytes);
    if (stream_q.size() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time, stream_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_checksummed_frame_builder_top: PASS");
    end else begin
      $display("tb_checksummed_frame_builder_top: FAIL");
    end
    $finish;
  end

endmodule
